// ===== hw/rtl/adsc_pkg.sv =====
// Shared constants, types and the helper function of the area-average downscaler.
`default_nettype none
package adsc_pkg;

   localparam int MAX_COLS     = 4096;
   localparam int MAX_ROWS     = 4096;
   localparam int MAX_CHANNELS = 4;

   localparam int DIM_W  = 13;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CH_W   = 3;
   localparam int PIX_W  = 8;
   localparam int ACC_W  = 32;
   localparam int PROD_W = 2 * DIM_W;
   localparam int DSH_W  = PROD_W + PIX_W - 1;
   localparam int QCNT_W = $clog2(PIX_W);
   localparam int FCNT_W = $clog2(DIM_W);
   localparam int IDX_W  = 3;

   localparam logic [IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] CSR_BOX_WIDTH  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_BOX_HEIGHT = 3'd3;
   localparam logic [IDX_W-1:0] CSR_CHANNELS   = 3'd4;

   typedef struct packed {
      logic [PROD_W-1:0] lt;
      logic [PROD_W-1:0] lb;
      logic [PROD_W-1:0] rt;
      logic [PROD_W-1:0] rb;
   } wprod_type;

   typedef struct packed {
      logic             clr;
      logic             capture;
      logic             lmul;
      logic             acc0;
      logic             acc1;
      logic             div_step;
      logic             emit;
      logic             row_done;
      logic             wr_nz;
      logic             rd_en;
      logic [COL_W-1:0] rd_addr;
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
   } lane_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic [DIM_W-1:0]  w;
      logic [DIM_W-1:0]  h;
      logic [PROD_W-1:0] area;
   } fit_res_type;

   // Zero counts as one, anything above hi counts as hi.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/adsc_if.sv =====
// Valid/ready channel interfaces for source pixels and destination pixels.
`default_nettype none
interface adsc_req_if;
   logic                        valid;
   logic                        ready;
   logic [adsc_pkg::PIX_W-1:0]  chan0;
   logic [adsc_pkg::PIX_W-1:0]  chan1;
   logic [adsc_pkg::PIX_W-1:0]  chan2;
   logic [adsc_pkg::PIX_W-1:0]  chan3;

   modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                   input ready);
   modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
                 output ready);
endinterface

interface adsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [adsc_pkg::PIX_W-1:0]  out_chan0;
   logic [adsc_pkg::PIX_W-1:0]  out_chan1;
   logic [adsc_pkg::PIX_W-1:0]  out_chan2;
   logic [adsc_pkg::PIX_W-1:0]  out_chan3;
   logic [adsc_pkg::COL_W-1:0]  out_col;
   logic [adsc_pkg::ROW_W-1:0]  out_row;
   logic                        frame_end;

   modport source (output valid, output out_chan0, output out_chan1, output out_chan2,
                   output out_chan3, output out_col, output out_row, output frame_end,
                   input ready);
   modport sink (input valid, input out_chan0, input out_chan1, input out_chan2,
                 input out_chan3, input out_col, input out_row, input frame_end,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/adsc_fit.sv =====
// Output size fitting: aspect-preserving fit of the box plus the pixel area product.
`default_nettype none
module adsc_fit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [adsc_pkg::DIM_W-1:0]    sw,
   input  wire [adsc_pkg::DIM_W-1:0]    sh,
   input  wire [adsc_pkg::DIM_W-1:0]    bw,
   input  wire [adsc_pkg::DIM_W-1:0]    bh,
   output adsc_pkg::fit_res_type        res
);

   typedef enum logic [4:0] {
      FIT_MUL  = 5'b00001,
      FIT_SEL  = 5'b00010,
      FIT_DIV  = 5'b00100,
      FIT_FIN  = 5'b01000,
      FIT_DONE = 5'b10000
   } fit_state_type;

   fit_state_type                     state_ff, state_in;
   logic [adsc_pkg::PROD_W-1:0]       p1_ff, p2_ff, area_ff;
   logic [adsc_pkg::PROD_W-1:0]       rem_ff, dsh_ff;
   logic [adsc_pkg::DIM_W-1:0]        q_ff, w_ff, h_ff;
   logic [adsc_pkg::FCNT_W-1:0]       cnt_ff;
   logic                              by_width_ff;
   logic                              ge;
   logic [adsc_pkg::DIM_W-1:0]        w_raw, h_raw;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FIT_MUL:  state_in = FIT_SEL;
         FIT_SEL:  state_in = FIT_DIV;
         FIT_DIV: begin
            if (cnt_ff == adsc_pkg::FCNT_W'(adsc_pkg::DIM_W - 1)) state_in = FIT_FIN;
         end
         FIT_FIN:  state_in = FIT_DONE;
         FIT_DONE: state_in = FIT_DONE;
         default:  state_in = FIT_DONE;
      endcase
      if (start) state_in = FIT_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIT_MUL;
      end else begin
         state_ff <= state_in;
      end
   end

   // The quotient lands on whichever side the comparison did not pin to the box.
   assign w_raw = by_width_ff ? bw : q_ff;
   assign h_raw = by_width_ff ? q_ff : bh;

   always_ff @(posedge clock) begin
      case (state_ff)
         FIT_MUL: begin
            p1_ff   <= adsc_pkg::PROD_W'(bw) * adsc_pkg::PROD_W'(sh);
            p2_ff   <= adsc_pkg::PROD_W'(bh) * adsc_pkg::PROD_W'(sw);
            area_ff <= adsc_pkg::PROD_W'(sw) * adsc_pkg::PROD_W'(sh);
         end
         FIT_SEL: begin
            by_width_ff <= p1_ff < p2_ff;
            rem_ff      <= (p1_ff < p2_ff) ? p1_ff : p2_ff;
            dsh_ff      <= adsc_pkg::PROD_W'((p1_ff < p2_ff) ? sw : sh)
                           << (adsc_pkg::DIM_W - 1);
            q_ff        <= '0;
            cnt_ff      <= '0;
         end
         FIT_DIV: begin
            if (ge) rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[adsc_pkg::DIM_W-2:0], ge};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff + adsc_pkg::FCNT_W'(1);
         end
         FIT_FIN: begin
            w_ff <= adsc_pkg::clamp_dim(w_raw, sw);
            h_ff <= adsc_pkg::clamp_dim(h_raw, sh);
         end
         default: begin
         end
      endcase
   end

   assign res.busy = (state_ff != FIT_DONE);
   assign res.w    = w_ff;
   assign res.h    = h_ff;
   assign res.area = area_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/adsc_lane.sv =====
// One channel lane: row accumulator memory, straddle carry and the averaging divider.
`default_nettype none
module adsc_lane (
   input  wire                               clock,
   input  wire adsc_pkg::lane_ctrl_type      ctrl,
   input  wire                               active,
   input  wire [adsc_pkg::PIX_W-1:0]         pix,
   input  wire adsc_pkg::wprod_type          wprod,
   input  wire [adsc_pkg::PROD_W-1:0]        area,
   output logic [adsc_pkg::PIX_W-1:0]        quot
);

   localparam int MW = adsc_pkg::PROD_W + adsc_pkg::PIX_W;

   logic [adsc_pkg::ACC_W-1:0] mem [adsc_pkg::MAX_COLS];
   logic [adsc_pkg::ACC_W-1:0] rdata_ff;
   logic [adsc_pkg::PIX_W-1:0] pix_ff;
   logic [adsc_pkg::ACC_W-1:0] p_lt_ff, p_lb_ff, p_rt_ff, p_rb_ff;
   logic [adsc_pkg::ACC_W-1:0] carry_ff;
   logic [adsc_pkg::DSH_W-1:0] rem_ff, dsh_ff;
   logic [adsc_pkg::PIX_W-1:0] quot_ff;
   logic [MW-1:0]              m_lt, m_lb, m_rt, m_rb;
   logic [adsc_pkg::ACC_W-1:0] s0, k1, wdata;
   logic                       ge;

   assign m_lt = MW'(pix_ff) * MW'(wprod.lt);
   assign m_lb = MW'(pix_ff) * MW'(wprod.lb);
   assign m_rt = MW'(pix_ff) * MW'(wprod.rt);
   assign m_rb = MW'(pix_ff) * MW'(wprod.rb);

   assign s0 = rdata_ff + p_lt_ff;
   assign k1 = ctrl.row_done ? (carry_ff + p_lb_ff) : carry_ff;

   always_comb begin
      if (ctrl.clr) begin
         wdata = '0;
      end else if (ctrl.acc0) begin
         wdata = ctrl.emit ? k1 : s0;
      end else begin
         wdata = rdata_ff + p_rt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) mem[ctrl.wr_addr] <= wdata;
      if (ctrl.rd_en) rdata_ff <= mem[ctrl.rd_addr];
   end

   assign ge = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (ctrl.clr) carry_ff <= '0;
      if (ctrl.capture) pix_ff <= active ? pix : '0;
      if (ctrl.lmul) begin
         p_lt_ff <= adsc_pkg::ACC_W'(m_lt);
         p_lb_ff <= adsc_pkg::ACC_W'(m_lb);
         p_rt_ff <= adsc_pkg::ACC_W'(m_rt);
         p_rb_ff <= adsc_pkg::ACC_W'(m_rb);
      end
      if (ctrl.acc0) begin
         // The lower part of a pixel that also spills right starts the next column.
         if (ctrl.wr_nz && ctrl.row_done) begin
            carry_ff <= p_rb_ff;
         end else if (ctrl.emit) begin
            carry_ff <= '0;
         end else begin
            carry_ff <= k1;
         end
         if (ctrl.emit) begin
            rem_ff  <= adsc_pkg::DSH_W'(s0);
            dsh_ff  <= adsc_pkg::DSH_W'(area) << (adsc_pkg::PIX_W - 1);
            quot_ff <= '0;
         end
      end
      if (ctrl.div_step) begin
         if (ge) rem_ff <= rem_ff - dsh_ff;
         quot_ff <= {quot_ff[adsc_pkg::PIX_W-2:0], ge};
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/area_average_image_downscale_top.sv =====
// Top level of the area-averaging box downscaler: sequencer, position tracking, lanes, output.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+---------------------------------------------
//  req_ch    | in  | valid / ready       | chan0..chan3, one source pixel per item
//  rsp_ch    | out | valid / ready       | out_chan0..3, out_col, out_row, frame_end
//  csr_*     | in  | csr_we, no wait     | csr_index selects register, csr_wdata value
//
// A source item that completes no destination pixel runs the four product and
// accumulate steps, one read-modify-write per memory port; one that completes
// a destination pixel also runs the eight steps of the per-lane restoring divider.
// After reset and after every register write the row memory of each lane is
// swept to zero, all MAX_COLS (4096) addresses, while req_ch.ready stays low.
// A finished item sits in the output register; the block keeps taking source
// items while it waits, and stalls only when a second result is due first.
`default_nettype none
module area_average_image_downscale_top (
   input  wire                             clock,
   input  wire                             reset,
   adsc_req_if.sink                        req_ch,
   adsc_rsp_if.source                      rsp_ch,
   input  wire                             csr_we,
   input  wire [adsc_pkg::IDX_W-1:0]       csr_index,
   input  wire [adsc_pkg::DIM_W-1:0]       csr_wdata
);

   localparam int NCH   = adsc_pkg::MAX_CHANNELS;
   localparam int DIM_W = adsc_pkg::DIM_W;
   localparam int COL_W = adsc_pkg::COL_W;
   localparam int ROW_W = adsc_pkg::ROW_W;

   // Sequencer states, one item at a time.
   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_MUL   = 8'b00000100,
      ST_LMUL  = 8'b00001000,
      ST_ACC0  = 8'b00010000,
      ST_ACC1  = 8'b00100000,
      ST_DIV   = 8'b01000000,
      ST_EMIT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers, held raw; range limits are applied on use.
   logic [DIM_W-1:0]            src_width_ff, src_height_ff, box_width_ff, box_height_ff;
   logic [adsc_pkg::CH_W-1:0]   channels_ff;
   logic                        cfg_hit;
   logic [DIM_W-1:0]            sw, sh, bw, bh, fw, fh;
   logic [adsc_pkg::CH_W-1:0]   nch;
   adsc_pkg::fit_res_type       fit;

   assign cfg_hit = csr_we && (csr_index <= adsc_pkg::CSR_CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(1);
         src_height_ff <= DIM_W'(1);
         box_width_ff  <= DIM_W'(1);
         box_height_ff <= DIM_W'(1);
         channels_ff   <= adsc_pkg::CH_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            adsc_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            adsc_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            adsc_pkg::CSR_BOX_WIDTH:  box_width_ff  <= csr_wdata;
            adsc_pkg::CSR_BOX_HEIGHT: box_height_ff <= csr_wdata;
            adsc_pkg::CSR_CHANNELS:   channels_ff   <= csr_wdata[adsc_pkg::CH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign sw = adsc_pkg::clamp_dim(src_width_ff,  DIM_W'(adsc_pkg::MAX_COLS));
   assign sh = adsc_pkg::clamp_dim(src_height_ff, DIM_W'(adsc_pkg::MAX_ROWS));
   assign bw = adsc_pkg::clamp_dim(box_width_ff,  DIM_W'(adsc_pkg::MAX_COLS));
   assign bh = adsc_pkg::clamp_dim(box_height_ff, DIM_W'(adsc_pkg::MAX_ROWS));

   always_comb begin
      if (channels_ff == '0) begin
         nch = adsc_pkg::CH_W'(1);
      end else if (channels_ff > adsc_pkg::CH_W'(NCH)) begin
         nch = adsc_pkg::CH_W'(NCH);
      end else begin
         nch = channels_ff;
      end
   end

   adsc_fit u_fit (
      .clock (clock),
      .reset (reset),
      .start (cfg_hit),
      .sw    (sw),
      .sh    (sh),
      .bw    (bw),
      .bh    (bh),
      .res   (fit)
   );

   assign fw = fit.w;
   assign fh = fit.h;

   // Position tracking. The destination column and the remainder inside it step
   // by fw per source pixel; fw never exceeds sw, so one subtract keeps it in range.
   logic [COL_W-1:0] x_ff, cx_ff, remx_ff;
   logic [ROW_W-1:0] y_ff, ry_ff, remy_ff;
   logic [DIM_W:0]   sumx, sumy, swx, shx;
   logic             col_wrap, row_wrap, x_last, y_last, accept;
   logic [DIM_W-1:0] wl_in, wr_in, wt_in, wb_in;

   assign accept = req_ch.valid && req_ch.ready;

   assign swx  = {1'b0, sw};
   assign shx  = {1'b0, sh};
   assign sumx = {1'b0, DIM_W'(remx_ff)} + {1'b0, fw};
   assign sumy = {1'b0, DIM_W'(remy_ff)} + {1'b0, fh};

   assign col_wrap = sumx >= swx;
   assign row_wrap = sumy >= shx;
   assign x_last   = (DIM_W'(x_ff) + DIM_W'(1)) == sw;
   assign y_last   = (DIM_W'(y_ff) + DIM_W'(1)) == sh;

   // A pixel that crosses a boundary splits into a left/top and a right/bottom part.
   assign wl_in = col_wrap ? (sw - DIM_W'(remx_ff)) : fw;
   assign wr_in = col_wrap ? DIM_W'(sumx - swx) : '0;
   assign wt_in = row_wrap ? (sh - DIM_W'(remy_ff)) : fh;
   assign wb_in = row_wrap ? DIM_W'(sumy - shx) : '0;

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         x_ff    <= '0;
         cx_ff   <= '0;
         remx_ff <= '0;
         y_ff    <= '0;
         ry_ff   <= '0;
         remy_ff <= '0;
      end else if (accept) begin
         if (x_last) begin
            x_ff    <= '0;
            cx_ff   <= '0;
            remx_ff <= '0;
            if (y_last) begin
               y_ff    <= '0;
               ry_ff   <= '0;
               remy_ff <= '0;
            end else begin
               y_ff <= y_ff + ROW_W'(1);
               if (row_wrap) begin
                  ry_ff   <= ry_ff + ROW_W'(1);
                  remy_ff <= ROW_W'(sumy - shx);
               end else begin
                  remy_ff <= ROW_W'(sumy);
               end
            end
         end else begin
            x_ff <= x_ff + COL_W'(1);
            if (col_wrap) begin
               cx_ff   <= cx_ff + COL_W'(1);
               remx_ff <= COL_W'(sumx - swx);
            end else begin
               remx_ff <= COL_W'(sumx);
            end
         end
      end
   end

   // Per-item registers captured at accept; the weight products are formed in ST_MUL.
   logic [DIM_W-1:0]   wl_ff, wr_ff, wt_ff, wb_ff;
   logic               col_done_ff, row_done_ff, wr_nz_ff;
   logic [COL_W-1:0]   c_ff;
   logic [ROW_W-1:0]   r_ff;
   adsc_pkg::wprod_type wprod_ff;
   logic               emit;

   assign emit = col_done_ff && row_done_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         wl_ff       <= wl_in;
         wr_ff       <= wr_in;
         wt_ff       <= wt_in;
         wb_ff       <= wb_in;
         col_done_ff <= col_wrap;
         row_done_ff <= row_wrap;
         wr_nz_ff    <= sumx > swx;
         c_ff        <= cx_ff;
         r_ff        <= ry_ff;
      end
      if (state_ff == ST_MUL) begin
         wprod_ff.lt <= adsc_pkg::PROD_W'(wl_ff) * adsc_pkg::PROD_W'(wt_ff);
         wprod_ff.lb <= adsc_pkg::PROD_W'(wl_ff) * adsc_pkg::PROD_W'(wb_ff);
         wprod_ff.rt <= adsc_pkg::PROD_W'(wr_ff) * adsc_pkg::PROD_W'(wt_ff);
         wprod_ff.rb <= adsc_pkg::PROD_W'(wr_ff) * adsc_pkg::PROD_W'(wb_ff);
      end
   end

   // Sequencer counters: clearing sweep address and divider step.
   logic [COL_W-1:0]            clr_cnt_ff;
   logic [adsc_pkg::QCNT_W-1:0] div_cnt_ff;
   logic                        clr_last, div_last, out_free, load_out;
   logic                        rsp_valid_ff;

   assign clr_last = clr_cnt_ff == COL_W'(adsc_pkg::MAX_COLS - 1);
   assign div_last = div_cnt_ff == adsc_pkg::QCNT_W'(adsc_pkg::PIX_W - 1);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_out = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last && !fit.busy) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_MUL;
         ST_MUL:   state_in = ST_LMUL;
         ST_LMUL:  state_in = ST_ACC0;
         ST_ACC0:  state_in = ST_ACC1;
         ST_ACC1:  state_in = emit ? ST_DIV : ST_IDLE;
         ST_DIV:   if (div_last) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
      if (cfg_hit) state_in = ST_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_hit) begin
            clr_cnt_ff <= '0;
         end else if (state_ff == ST_CLEAR && !clr_last) begin
            clr_cnt_ff <= clr_cnt_ff + COL_W'(1);
         end
         if (state_ff == ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + adsc_pkg::QCNT_W'(1);
         end else begin
            div_cnt_ff <= '0;
         end
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Lane control: one shared word drives all lanes in lockstep.
   adsc_pkg::lane_ctrl_type ctrl;

   always_comb begin
      ctrl          = '0;
      ctrl.emit     = emit;
      ctrl.row_done = row_done_ff;
      ctrl.wr_nz    = wr_nz_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clr     = 1'b1;
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            ctrl.capture = accept;
            ctrl.rd_en   = accept;
            ctrl.rd_addr = cx_ff;
         end
         ST_LMUL: ctrl.lmul = 1'b1;
         ST_ACC0: begin
            // Update the open column and fetch the one to its right.
            ctrl.acc0    = 1'b1;
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = c_ff;
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = c_ff + COL_W'(1);
         end
         ST_ACC1: begin
            ctrl.acc1    = 1'b1;
            ctrl.wr_en   = wr_nz_ff;
            ctrl.wr_addr = c_ff + COL_W'(1);
         end
         ST_DIV:  ctrl.div_step = 1'b1;
         default: begin
         end
      endcase
   end

   // Channel lanes.
   logic [adsc_pkg::PIX_W-1:0] pix_in [NCH];
   logic [adsc_pkg::PIX_W-1:0] quot [NCH];

   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         case (k)
            0:       pix_in[k] = req_ch.chan0;
            1:       pix_in[k] = req_ch.chan1;
            2:       pix_in[k] = req_ch.chan2;
            default: pix_in[k] = req_ch.chan3;
         endcase
      end
   end

   for (genvar k = 0; k < NCH; k++) begin : g_lane
      adsc_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .active (adsc_pkg::CH_W'(k) < nch),
         .pix    (pix_in[k]),
         .wprod  (wprod_ff),
         .area   (fit.area),
         .quot   (quot[k])
      );
   end

   // Merge stage: the output register gathers the lane quotients and the position.
   logic [adsc_pkg::PIX_W-1:0] out_chan_ff [4];
   logic [COL_W-1:0]           out_col_ff;
   logic [ROW_W-1:0]           out_row_ff;
   logic                       frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int k = 0; k < 4; k++) begin
            out_chan_ff[k] <= (k < NCH) ? quot[k] : '0;
         end
         out_col_ff   <= c_ff;
         out_row_ff   <= r_ff;
         frame_end_ff <= ((DIM_W'(c_ff) + DIM_W'(1)) == fw) &&
                         ((DIM_W'(r_ff) + DIM_W'(1)) == fh);
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_chan0 = out_chan_ff[0];
   assign rsp_ch.out_chan1 = out_chan_ff[1];
   assign rsp_ch.out_chan2 = out_chan_ff[2];
   assign rsp_ch.out_chan3 = out_chan_ff[3];
   assign rsp_ch.out_col   = out_col_ff;
   assign rsp_ch.out_row   = out_row_ff;
   assign rsp_ch.frame_end = frame_end_ff;

`ifndef SYNTHESIS
   // Only one source item is in flight at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("source item accepted while another is in flight");

   // Items are taken only once the size fit is settled.
   a_fit_ready: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !fit.busy)
      else $error("ready while the size fit is still running");

   // The column and row remainders stay below one destination pixel span.
   a_remx: assert property (@(posedge clock) disable iff (reset)
      accept |-> (DIM_W'(remx_ff) < sw))
      else $error("column remainder out of range");

   a_remy: assert property (@(posedge clock) disable iff (reset)
      accept |-> (DIM_W'(remy_ff) < sh))
      else $error("row remainder out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_area_average_image_downscale_top.sv =====
// Self-checking testbench of the area-averaging box downscaler top level.
`default_nettype none
module tb_area_average_image_downscale_top;
   import adsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // One destination pixel as the block should deliver it.
   typedef struct {
      bit [PIX_W-1:0] chan [MAX_CHANNELS];
      bit [COL_W-1:0] col;
      bit [ROW_W-1:0] row;
      bit             last;
   } dst_pixel_t;

   // Cycles to let pass after the last result before a register write or the end.
   // An item that completes no destination pixel can still be in flight after
   // the last result, so the pause is longer than an item that completes one.
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_wdata;

   adsc_req_if req_ch ();
   adsc_rsp_if rsp_ch ();

   area_average_image_downscale_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the registers and the state of the downscaler.
   bit [DIM_W-1:0] reg_src_w, reg_src_h, reg_box_w, reg_box_h;
   bit [CH_W-1:0]  reg_chans;
   bit [31:0]      row_sums [MAX_COLS*MAX_CHANNELS];
   bit [31:0]      split_sums [MAX_CHANNELS];
   longint unsigned next_x, next_y, out_w, out_h;

   dst_pixel_t pending_pixels [$];
   int         error_count;
   int         stall_hold;     // cycles the receiver still holds off
   bit         steady_mode;    // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The limit covers roughly a hundred memory sweeps, several hundred
   // items with idling on both sides, and a wide margin.
   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Fits the output size into the box and restarts the frame with cleared sums.
   function automatic void fit_output();
      longint unsigned sw, sh, bw, bh, w, h;
      sw = clamp_size(reg_src_w, MAX_COLS);
      sh = clamp_size(reg_src_h, MAX_ROWS);
      bw = clamp_size(reg_box_w, MAX_COLS);
      bh = clamp_size(reg_box_h, MAX_ROWS);
      if (bw * sh < bh * sw) begin
         w = bw;
         h = w * sh / sw;
      end else begin
         h = bh;
         w = h * sw / sh;
      end
      out_w = clamp_size(w, sw);
      out_h = clamp_size(h, sh);
      next_x = 0;
      next_y = 0;
      foreach (row_sums[i]) row_sums[i] = '0;
      foreach (split_sums[i]) split_sums[i] = '0;
   endfunction

   function automatic void shadow_write(bit [IDX_W-1:0] idx, bit [DIM_W-1:0] value);
      case (idx)
         CSR_SRC_WIDTH:  reg_src_w = value;
         CSR_SRC_HEIGHT: reg_src_h = value;
         CSR_BOX_WIDTH:  reg_box_w = value;
         CSR_BOX_HEIGHT: reg_box_h = value;
         CSR_CHANNELS:   reg_chans = value[CH_W-1:0];
         default: return;
      endcase
      fit_output();
   endfunction

   // Accumulates one source pixel by overlap area; queues a destination pixel
   // when the pixel closes both its destination column and row.
   function automatic void accumulate_pixel(bit [PIX_W-1:0] px [MAX_CHANNELS]);
      longint unsigned sw, sh, nch, x, y, xa, xb, c, bx, wl, wr, ya, yb, r, by, wt, wb, v;
      bit col_done, row_done;
      dst_pixel_t d;
      sw = clamp_size(reg_src_w, MAX_COLS);
      sh = clamp_size(reg_src_h, MAX_ROWS);
      nch = clamp_size(reg_chans, MAX_CHANNELS);
      x = (next_x >= sw) ? 0 : next_x;
      y = (next_y >= sh) ? 0 : next_y;
      xa = x * out_w; xb = xa + out_w; c = xa / sw; bx = (c + 1) * sw;
      if (xb <= bx) begin
         wl = out_w; wr = 0; col_done = (xb == bx);
      end else begin
         wl = bx - xa; wr = xb - bx; col_done = 1'b1;
      end
      ya = y * out_h; yb = ya + out_h; r = ya / sh; by = (r + 1) * sh;
      if (yb <= by) begin
         wt = out_h; wb = 0; row_done = (yb == by);
      end else begin
         wt = by - ya; wb = yb - by; row_done = 1'b1;
      end
      foreach (d.chan[k]) d.chan[k] = '0;
      for (int k = 0; k < nch; k++) begin
         v = px[k];
         row_sums[c*MAX_CHANNELS+k] = 32'(row_sums[c*MAX_CHANNELS+k] + v * wl * wt);
         if (row_done) split_sums[k] = 32'(split_sums[k] + v * wl * wb);
         if (row_done && col_done) begin
            d.chan[k] = PIX_W'(longint'(row_sums[c*MAX_CHANNELS+k]) / (sw * sh));
            row_sums[c*MAX_CHANNELS+k] = split_sums[k];
            split_sums[k] = '0;
         end
         if (wr > 0 && c + 1 < MAX_COLS) begin
            row_sums[(c+1)*MAX_CHANNELS+k] =
               32'(row_sums[(c+1)*MAX_CHANNELS+k] + v * wr * wt);
            if (row_done) split_sums[k] = 32'(v * wr * wb);
         end
      end
      x++;
      if (x >= sw) begin
         x = 0;
         y++;
         if (y >= sh) y = 0;
      end
      next_x = x;
      next_y = y;
      if (row_done && col_done) begin
         d.col = COL_W'(c);
         d.row = ROW_W'(r);
         d.last = (c + 1 == out_w) && (r + 1 == out_h);
         pending_pixels.push_back(d);
      end
   endfunction

   // Every accepted source item goes through the shadow downscaler.
   always @(posedge clock) begin
      bit [PIX_W-1:0] px [MAX_CHANNELS];
      if (!reset && req_ch.valid && req_ch.ready) begin
         px[0] = req_ch.chan0;
         px[1] = req_ch.chan1;
         px[2] = req_ch.chan2;
         px[3] = req_ch.chan3;
         accumulate_pixel(px);
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Every delivered destination item is compared with the oldest expectation.
   always @(posedge clock) begin
      dst_pixel_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("expected items waiting", 0, 1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.out_chan0 != want.chan[0])
               report_mismatch("out_chan0", rsp_ch.out_chan0, want.chan[0]);
            if (rsp_ch.out_chan1 != want.chan[1])
               report_mismatch("out_chan1", rsp_ch.out_chan1, want.chan[1]);
            if (rsp_ch.out_chan2 != want.chan[2])
               report_mismatch("out_chan2", rsp_ch.out_chan2, want.chan[2]);
            if (rsp_ch.out_chan3 != want.chan[3])
               report_mismatch("out_chan3", rsp_ch.out_chan3, want.chan[3]);
            if (rsp_ch.out_col != want.col)
               report_mismatch("out_col", rsp_ch.out_col, want.col);
            if (rsp_ch.out_row != want.row)
               report_mismatch("out_row", rsp_ch.out_row, want.row);
            if (rsp_ch.frame_end != want.last)
               report_mismatch("frame_end", rsp_ch.frame_end, want.last);
         end
      end
   end

   // The receiver: random stalls, none in steady mode, and a long hold-off
   // whenever a test loads stall_hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_ch.ready <= steady_mode || ($urandom_range(99) >= 38);
      end
   end

   // Offers one source item, with a random gap first, and returns at the
   // edge where it is taken. Valid is driven once per edge.
   task automatic send_pixel(bit [PIX_W-1:0] c0, c1, c2, c3);
      int gap;
      gap = 0;
      if (!steady_mode && $urandom_range(99) < 38) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.chan0 <= c0;
      req_ch.chan1 <= c1;
      req_ch.chan2 <= c2;
      req_ch.chan3 <= c3;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_pixels(int count);
      repeat (count)
         send_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                    PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)));
   endtask

   // Lowers valid and waits until every expected item has come back and the
   // block has had time to finish anything still in flight.
   task automatic drain();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0 && guard < 200_000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the block drained.
   task automatic write_reg(bit [IDX_W-1:0] idx, bit [DIM_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      shadow_write(idx, value);
      csr_we <= 1'b0;
   endtask

   task automatic set_frame(bit [DIM_W-1:0] sw, sh, bw, bh, bit [CH_W-1:0] ch);
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_BOX_WIDTH, bw);
      write_reg(CSR_BOX_HEIGHT, bh);
      write_reg(CSR_CHANNELS, ch);
   endtask

   // Reset values give a one-pixel frame with three channels: every item
   // comes back unchanged except channel 3, which reads zero.
   task automatic test_reset_defaults();
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hA5, 8'h5A, 8'h0F, 8'hF0);
      drain();
   endtask

   // Channel counts of zero and above the maximum are clamped.
   task automatic test_channel_counts();
      bit [CH_W-1:0] counts [5] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7};
      foreach (counts[i]) begin
         write_reg(CSR_CHANNELS, counts[i]);
         send_pixel(8'hFF, 8'h81, 8'h7E, 8'h01);
      end
      drain();
   endtask

   // Size extremes: oversize and zero registers clamp; a zero box collapses
   // the frame to one truncated average; a full-size box passes pixels through.
   task automatic test_size_extremes();
      set_frame(13'd8191, 13'd0, 13'd8191, 13'd8191, 3'd4);
      send_random_pixels(4);
      set_frame(13'd5, 13'd3, 13'd0, 13'd0, 3'd4);
      repeat (15) send_pixel(8'hFF, 8'hFE, 8'h01, 8'h80);
      set_frame(13'd0, 13'd8191, 13'd2, 13'd4096, 3'd2);
      send_random_pixels(3);
      // A write to an index beyond the register list is ignored.
      write_reg(IDX_W'(5), 13'h1FFF);
      write_reg(IDX_W'(7), 13'h0AAA);
      send_random_pixels(2);
      drain();
   endtask

   // Pixel-exact straddling: a 7x5 source into a 3x3 box (a 3x2 result) splits
   // pixels across both column and row boundaries.
   task automatic test_straddling();
      set_frame(13'd7, 13'd5, 13'd3, 13'd3, 3'd3);
      send_random_pixels(35);
      drain();
   endtask

   // The receiver holds off while the sender keeps offering identity-scaled
   // items, so results back up and the input stalls.
   task automatic test_backpressure();
      set_frame(13'd4, 13'd4, 13'd4, 13'd4, 3'd4);
      steady_mode = 1'b1;
      stall_hold = 300;
      send_random_pixels(40);
      steady_mode = 1'b0;
      drain();
   endtask

   // Random small frames: mostly whole frames with random content, some cut
   // short, with one phase run with no idling at all.
   task automatic test_random_frames();
      int sent, n, pick;
      sent = 0;
      pick = 0;
      while (sent < 450) begin
         pick++;
         if ($urandom_range(1)) write_reg(CSR_SRC_WIDTH, DIM_W'($urandom_range(1, 9)));
         if ($urandom_range(1)) write_reg(CSR_SRC_HEIGHT, DIM_W'($urandom_range(1, 7)));
         if ($urandom_range(1)) write_reg(CSR_BOX_WIDTH, DIM_W'($urandom_range(0, 10)));
         if ($urandom_range(1)) write_reg(CSR_BOX_HEIGHT, DIM_W'($urandom_range(0, 8)));
         write_reg(CSR_CHANNELS, CH_W'($urandom_range(0, 7)));
         n = int'(clamp_size(reg_src_w, MAX_COLS) * clamp_size(reg_src_h, MAX_ROWS));
         if ($urandom_range(99) < 25) n = $urandom_range(1, n);
         else n = n * $urandom_range(1, 2);
         steady_mode = (pick == 6);
         send_random_pixels(n);
         steady_mode = 1'b0;
         sent += n;
      end
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.chan0 = '0;
      req_ch.chan1 = '0;
      req_ch.chan2 = '0;
      req_ch.chan3 = '0;
      error_count  = 0;
      stall_hold   = 0;
      steady_mode  = 1'b0;
      reg_src_w = 13'd1;
      reg_src_h = 13'd1;
      reg_box_w = 13'd1;
      reg_box_h = 13'd1;
      reg_chans = 3'd3;
      fit_output();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_channel_counts();
      test_size_extremes();
      test_straddling();
      test_backpressure();
      test_random_frames();

      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (pending_pixels.size() != 0)
            $display("%0d destination items never arrived", pending_pixels.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
